// ===== rtl/tdht_pkg.sv =====
// Shared types and constants for the texture descriptor hash table.
// Holds operation codes, beat widths, the descriptor layout and the
// controller/datapath command and status structs. No dependencies.
package tdht_pkg;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 96;
    localparam int KEY_W      = 31;
    localparam int DESC_W     = 64;
    localparam int SLOT_W     = KEY_W + DESC_W;

    typedef struct packed {
        logic [8:0]  count;
        logic [7:0]  hl1;
        logic [7:0]  wl1;
        logic [7:0]  offy;
        logic [7:0]  offx;
        logic [14:0] pal;
        logic [7:0]  page;
    } desc_t;

    typedef struct packed {
        logic load;
        logic idx_zero;
        logic idx_init;
        logic idx_adv;
        logic capture;
        logic wr_en;
        logic wr_clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       mod_done;
        logic       found;
        logic       probe_last;
        logic       idx_last;
        logic       out_free;
    } status_t;

endpackage

// ===== rtl/tdht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tdht_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tdht_ctrl.sv =====
// Controller FSM for the texture descriptor hash table.
// Sequences accept, modulo, probe, clearing sweep and result hand-off. Uses tdht_pkg.
module tdht_ctrl
    import tdht_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_func,
    input  status_t    status,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_RST_CLR = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_MOD     = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_CLR     = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_RST_CLR, ST_CLR: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_clear = 1'b1;
                if (status.idx_last) begin
                    state_next = (state_reg == ST_CLR) ? ST_FIN : ST_IDLE;
                end else begin
                    cmd.idx_adv = 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    priority if (s_func == FUNC_LOOKUP || s_func == FUNC_SET) begin
                        state_next = ST_MOD;
                    end else if (s_func == FUNC_CLEAR) begin
                        cmd.idx_zero = 1'b1;
                        state_next   = ST_CLR;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MOD: begin
                if (status.mod_done) begin
                    cmd.idx_init = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.found || status.probe_last) begin
                    cmd.capture = 1'b1;
                    cmd.wr_en   = status.found && (status.op == FUNC_SET);
                    state_next  = ST_FIN;
                end else begin
                    cmd.idx_adv = 1'b1;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RST_CLR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/tdht_datapath.sv =====
// Datapath for the texture descriptor hash table: input latch, descriptor
// packing, id modulo unit, probe index, slot RAM and output register.
// Uses tdht_pkg and tdht_ram.
module tdht_datapath
    import tdht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    function automatic desc_t build_desc(input logic [IN_DATA_W-1:0] d);
        desc_t      r;
        logic       depth;
        logic [1:0] blend;
        logic [9:0] ix;
        logic [8:0] iy;
        logic [6:0] iw;
        logic [8:0] ih;
        logic [9:0] px;
        logic [8:0] py;
        depth   = d[31];
        blend   = d[33:32];
        ix      = d[43:34];
        iy      = d[52:44];
        iw      = d[59:53];
        ih      = d[68:60];
        px      = d[78:69];
        py      = d[87:79];
        r.page  = {depth, blend, iy[8], ix[9:6]};
        r.pal   = {py, px[9:4]};
        r.offx  = depth ? {1'b0, ix[5:0], 1'b0} : {ix[5:0], 2'b00};
        r.offy  = iy[7:0];
        r.wl1   = depth ? ({iw, 1'b0} - 8'd1) : ({iw[5:0], 2'b00} - 8'd1);
        r.hl1   = ih[7:0] - 8'd1;
        r.count = d[96:88];
        return r;
    endfunction

    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  id_reg;
    desc_t             built_reg;
    logic              res_hit_reg;
    logic              res_full_reg;
    desc_t             res_desc_reg;
    logic signed [31:0] missing_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  idx_adv_val;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  mod_result;
    logic              mod_done;
    logic              m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [1:0]        m_user_reg;

    logic [SLOT_W-1:0] rd_data;
    logic [SLOT_W-1:0] wr_data;
    logic [KEY_W-1:0]  rd_key;
    desc_t             rd_desc;
    logic              key_empty;
    logic              key_match;
    logic              found;
    logic              hit;

    // id modulo table size
    if (IS_POW2) begin : g_mask
        assign mod_result = id_reg[IDX_W-1:0];
        assign mod_done   = 1'b1;
    end else begin : g_recip
        // reciprocal multiply gives a quotient at most one low; one subtract fixes it
        localparam logic [KEY_W-1:0] RECIP   =
            KEY_W'((64'd1 << KEY_W) / 64'(TABLE_ENTRIES));
        localparam logic [IDX_W:0]   DIVISOR = (IDX_W + 1)'(TABLE_ENTRIES);

        logic [2*KEY_W-1:0] prod;
        logic [KEY_W-1:0]   quot_reg;
        logic [IDX_W:0]     qn_low;
        logic [IDX_W:0]     rem_raw_reg;
        logic [1:0]         wait_reg;

        assign prod   = {{KEY_W{1'b0}}, id_reg} * {{KEY_W{1'b0}}, RECIP};
        // only the low bits of quotient times divisor matter, the remainder is below 2N
        assign qn_low = quot_reg[IDX_W:0] * DIVISOR;

        always_ff @(posedge aclk) begin
            quot_reg    <= prod[2*KEY_W-1:KEY_W];
            rem_raw_reg <= id_reg[IDX_W:0] - qn_low;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                wait_reg <= 2'd0;
            end else if (cmd.load) begin
                wait_reg <= 2'd2;
            end else if (wait_reg != 2'd0) begin
                wait_reg <= wait_reg - 2'd1;
            end
        end

        assign mod_result = (rem_raw_reg >= DIVISOR) ? IDX_W'(rem_raw_reg - DIVISOR) :
                            rem_raw_reg[IDX_W-1:0];
        assign mod_done   = (wait_reg == 2'd0);
    end

    assign idx_adv_val = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    always_comb begin
        idx_next = idx_reg;
        priority if (cmd.idx_zero) begin
            idx_next = '0;
        end else if (cmd.idx_init) begin
            idx_next = mod_result;
        end else if (cmd.idx_adv) begin
            idx_next = idx_adv_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            if (cmd.idx_zero || cmd.idx_init) begin
                cnt_reg <= '0;
            end else if (cmd.idx_adv) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // read address follows idx_next so read data lines up with idx_reg
    assign wr_data = cmd.wr_clear ? '0 : {built_reg, id_reg};

    tdht_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slots (
        .clk     (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    assign rd_key    = rd_data[KEY_W-1:0];
    assign rd_desc   = rd_data[SLOT_W-1:KEY_W];
    assign key_empty = (rd_key == '0);
    assign key_match = (rd_key == id_reg);
    assign found     = key_empty || key_match;
    assign hit       = !key_empty && key_match;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_tuser;
            id_reg       <= s_tdata[KEY_W-1:0];
            built_reg    <= build_desc(s_tdata);
            res_hit_reg  <= 1'b0;
            res_full_reg <= 1'b0;
            res_desc_reg <= '0;
        end else if (cmd.capture) begin
            res_hit_reg  <= hit;
            res_full_reg <= !found;
            if (op_reg == FUNC_SET) begin
                res_desc_reg <= found ? built_reg : '0;
            end else begin
                res_desc_reg <= hit ? rd_desc : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            missing_reg <= -32'sd1;
        end else if (cmd.capture && op_reg == FUNC_LOOKUP && !hit) begin
            missing_reg <= signed'({1'b0, id_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= {missing_reg, res_desc_reg};
            m_user_reg <= {res_full_reg, res_hit_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign status.op         = op_reg;
    assign status.mod_done   = mod_done;
    assign status.found      = found;
    assign status.probe_last = (cnt_reg == LAST_IDX);
    assign status.idx_last   = (idx_reg == LAST_IDX);
    assign status.out_free   = !m_valid_reg || m_tready;

endmodule

// ===== rtl/texture_descriptor_hash_table_top.sv =====
// Top level of the texture descriptor hash table (open addressing, linear probing).
// Instantiates tdht_ctrl and tdht_datapath; uses tdht_pkg.
//
//  channel  dir  tvalid/tready      tdata / tuser
//  s_       in   s_tvalid/s_tready  104-bit request, tuser = func
//  m_       out  m_tvalid/m_tready  96-bit result, tuser = {table_full, hit}
//
// Lookup or set: the id remainder, then slots probed in turn from it (1..TABLE_ENTRIES),
// then the result hand-off; when TABLE_ENTRIES is not a power of two the reciprocal
// id remainder goes through quot_reg and rem_raw_reg first. Clear: one slot RAM write a cycle.
// After reset a clearing pass over all TABLE_ENTRIES slots runs with s_tready low.
// One item is worked on at a time; the result register lets the next beat in
// while the previous result waits on m_tready.
module texture_descriptor_hash_table_top
    import tdht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 512
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tex_id[30:0] depth_mode[31] blend_rate[33:32] img_x[43:34] img_y[52:44]
    // img_w[59:53] img_h[68:60] pal_x[78:69] pal_y[87:79] colors[96:88], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // page_word[7:0] palette_word[22:8] offset_x[30:23] offset_y[38:31]
    // width_less_one[46:39] height_less_one[54:47] palette_count[63:55]
    // last_missing[95:64]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // hit[0] table_full[1]
    output logic [1:0]            m_tuser
);

    cmd_t    cmd;
    status_t status;

    tdht_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    tdht_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/tdht_checker.sv =====
// Port-level assertions for the texture descriptor hash table, bound to the top.
// Uses tdht_pkg for beat widths.
module tdht_checker
    import tdht_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // clearing pass after reset keeps the input closed and no result pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("activity right after reset");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit and table_full together");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[DESC_W-1:0] == '0)
        else $error("descriptor not zero on full table");

    // last_missing is either -1 or a 31-bit id
    a_missing_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OUT_DATA_W-1] |-> m_tdata[OUT_DATA_W-1:DESC_W] == 32'hFFFF_FFFF)
        else $error("last_missing out of range");

endmodule

bind texture_descriptor_hash_table_top tdht_checker u_tdht_checker (.*);
